// File: rtl/assert_macros.svh
// assertion helpers for the frame decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define SFACD_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sfacd assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SFACD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfacd assertion failed");

`else

`define SFACD_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define SFACD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/sfacd_pkg.sv
`timescale 1ns / 1ps

package sfacd_pkg;

	localparam logic [7:0] HDR_BYTE     = 8'hAA;
	localparam logic [7:0] TAIL_BYTE    = 8'hFF;
	localparam int unsigned PAYLOAD_LEN = 5;
	localparam int unsigned CNT_W       = 3;
	// count value at which the tail byte is due (header plus payload)
	localparam logic [CNT_W-1:0] CNT_TAIL = CNT_W'(PAYLOAD_LEN + 1);

	localparam logic [7:0] JOINT_BASE = 8'd105;
	localparam logic [7:0] JOINT_MAX  = 8'd165;
	localparam logic [7:0] CLAW_MAX   = 8'd140;

	localparam logic [1:0] MODE_AUTO = 2'd1;

	localparam logic [7:0] SEL_AUTO     = 8'h00;
	localparam logic [7:0] SEL_BASE     = 8'h01;
	localparam logic [7:0] SEL_JOINT    = 8'h02;
	localparam logic [7:0] SEL_CLAW     = 8'h03;
	localparam logic [7:0] SEL_BASE_JNT = 8'h04;
	localparam logic [7:0] SEL_BASE_CLW = 8'h05;
	localparam logic [7:0] SEL_JNT_CLW  = 8'h06;
	localparam logic [7:0] SEL_STOP     = 8'h07;

	localparam logic [1:0] BASE_HALT = 2'd0;
	localparam logic [1:0] BASE_BWD  = 2'd1;
	localparam logic [1:0] BASE_FWD  = 2'd2;

	localparam int unsigned TDATA_W = 32;

	typedef enum logic {
		ST_HUNT,
		ST_FRAME
	} frame_state_t;

	typedef logic [7:0] payload_t [PAYLOAD_LEN];

	// first member sits in the top bits, so the last field listed is the lowest
	typedef struct packed {
		logic [7:0] claw_angle;
		logic       claw_action;
		logic [7:0] joint_angle;
		logic       joint_action;
		logic [7:0] base_speed;
		logic [1:0] base_action;
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);

	function automatic cmd_t decode_frame(input logic [7:0] cw, input logic [7:0] ccw,
			input logic [7:0] rj, input logic [7:0] rc, input logic [7:0] sel);
		cmd_t       c;
		logic       eb;
		logic       ej;
		logic       ec;
		logic       stop_all;
		logic [8:0] jsum;
		eb = 1'b0;
		ej = 1'b0;
		ec = 1'b0;
		stop_all = (sel == SEL_STOP) ||
			(sel == SEL_BASE && cw == 8'd0 && ccw == 8'd0 && rj == 8'd0 && rc == 8'd0);
		if (!stop_all) begin
			unique case (sel)
				SEL_AUTO: begin
					eb = 1'b1;
					ej = (rj != 8'd0);
					ec = (rc != 8'd0);
				end
				SEL_BASE:     eb = 1'b1;
				SEL_JOINT:    ej = 1'b1;
				SEL_CLAW:     ec = 1'b1;
				SEL_BASE_JNT: begin
					eb = 1'b1;
					ej = 1'b1;
				end
				SEL_BASE_CLW: begin
					eb = 1'b1;
					ec = 1'b1;
				end
				SEL_JNT_CLW:  begin
					ej = 1'b1;
					ec = 1'b1;
				end
				default: ;
			endcase
		end
		c.base_action = BASE_HALT;
		c.base_speed  = 8'd0;
		if (eb) begin
			if (cw != 8'd0 && ccw == 8'd0) begin
				c.base_action = BASE_BWD;
				c.base_speed  = cw;
			end else if (ccw != 8'd0 && cw == 8'd0) begin
				c.base_action = BASE_FWD;
				c.base_speed  = ccw;
			end
		end
		jsum = {1'b0, JOINT_BASE} + {1'b0, rj};
		c.joint_action = ej;
		if (!ej) begin
			c.joint_angle = JOINT_BASE;
		end else if (jsum > {1'b0, JOINT_MAX}) begin
			c.joint_angle = JOINT_MAX;
		end else begin
			c.joint_angle = jsum[7:0];
		end
		c.claw_action = ec;
		if (!ec) begin
			c.claw_angle = 8'd0;
		end else if (rc > CLAW_MAX) begin
			c.claw_angle = CLAW_MAX;
		end else begin
			c.claw_angle = rc;
		end
		return c;
	endfunction

endpackage

// File: rtl/sync_frame_actuator_command_decoder.sv
`timescale 1ns / 1ps
// Frame decoder for a three-actuator arm, fed one received byte per transaction.
// s_axis: tdata[7:0] is rx_byte. The decoder hunts for the 0xAA header, stores
// the five payload bytes (cw, ccw, raw joint, raw claw, selector) and checks the
// seventh byte for 0xFF. A 0xAA inside a frame restarts it.
// m_axis: one command transaction per good frame while control_mode is 1.
// control_mode is written through control_mode_wr_en / control_mode_wr_data.
// Path: the tail byte is held in the input register, then the command in the
// result register, which drives m_axis.
// Throughput: one byte per cycle while m_axis_tready is high; both stages
// are a single register each, with one compare/add/clamp decode between them.
// Stall: if a command waits on m_axis, the input stage holds its byte and
// s_axis_tready drops only while both stages are full; when m_axis_tready is
// high the pipeline keeps moving every cycle.
// Reset (arst_n low): back to hunting, control_mode 0, no command pending.
// The payload bytes are not reset; they are always rewritten before a decode.

module sync_frame_actuator_command_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            control_mode_wr_en,
	input  logic [1:0]                      control_mode_wr_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // rx_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// base_action[1:0], base_speed[9:2], joint_action[10], joint_angle[18:11],
	// claw_action[19], claw_angle[27:20], zero fill
	output logic [sfacd_pkg::TDATA_W-1:0]   m_axis_tdata
);
	import sfacd_pkg::*;

`include "assert_macros.svh"

	logic [1:0]       control_mode_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	frame_state_t     state_q;
	frame_state_t     state_d;
	logic [CNT_W-1:0] byte_count_q;
	logic [CNT_W-1:0] byte_count_d;
	payload_t         payload_q;
	logic             store_en;
	logic             advance;
	logic             load_out;
	logic             out_valid_q;
	cmd_t             cmd_d;
	cmd_t             cmd_q;

	// stage 1 moves on when the result register is free or being emptied
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_mode_q <= 2'd0;
		end else if (control_mode_wr_en) begin
			control_mode_q <= control_mode_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// frame tracking for the byte in stage 1
	always_comb begin
		state_d      = state_q;
		byte_count_d = byte_count_q;
		store_en     = 1'b0;
		load_out     = 1'b0;
		if (valid_s1 && advance) begin
			unique case (state_q)
				ST_HUNT: begin
					if (byte_s1 == HDR_BYTE) begin
						state_d      = ST_FRAME;
						byte_count_d = CNT_W'(1);
					end
				end
				ST_FRAME: begin
					if (byte_s1 == HDR_BYTE) begin
						byte_count_d = CNT_W'(1);
					end else if (byte_count_q < CNT_TAIL) begin
						store_en     = 1'b1;
						byte_count_d = byte_count_q + CNT_W'(1);
					end else begin
						state_d      = ST_HUNT;
						byte_count_d = '0;
						load_out     = (byte_s1 == TAIL_BYTE) && (control_mode_q == MODE_AUTO);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HUNT;
			byte_count_q <= '0;
		end else begin
			state_q      <= state_d;
			byte_count_q <= byte_count_d;
		end
	end

	// payload slot is count minus one; counts 1..5 land in slots 0..4
	generate
		for (genvar i = 0; i < PAYLOAD_LEN; i++) begin : g_payload
			always_ff @(posedge clk) begin
				if (store_en && byte_count_q == CNT_W'(i + 1)) begin
					payload_q[i] <= byte_s1;
				end
			end
		end
	endgenerate

	assign cmd_d = decode_frame(payload_q[0], payload_q[1], payload_q[2],
		payload_q[3], payload_q[4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cmd_q <= cmd_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_W - CMD_W){1'b0}}, cmd_q};

	`SFACD_ASSERT_IMPLY(a_hunt_count_zero, clk, arst_n, state_q == ST_HUNT,
		byte_count_q == '0)
	`SFACD_ASSERT_IMPLY(a_frame_count_range, clk, arst_n, state_q == ST_FRAME,
		byte_count_q != '0 && byte_count_q <= CNT_TAIL)
	`SFACD_ASSERT_IMPLY(a_load_only_auto_tail, clk, arst_n, load_out,
		control_mode_q == MODE_AUTO && byte_s1 == TAIL_BYTE && state_q == ST_FRAME)
	`SFACD_ASSERT_IMPLY(a_out_angles_range, clk, arst_n, out_valid_q,
		cmd_q.joint_angle >= JOINT_BASE && cmd_q.joint_angle <= JOINT_MAX &&
		cmd_q.claw_angle <= CLAW_MAX)
	`SFACD_ASSERT_IMPLY(a_halt_no_speed, clk, arst_n,
		out_valid_q && cmd_q.base_action == BASE_HALT, cmd_q.base_speed == 8'd0)

endmodule

// File: tb/sync_frame_actuator_command_decoder_tb.sv
`timescale 1ns / 1ps

module sync_frame_actuator_command_decoder_tb;
	import sfacd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 6;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] cw;
		logic [7:0] ccw;
		logic [7:0] rj;
		logic [7:0] rc;
		logic [7:0] sel;
		logic [7:0] tail;
		int         cut;
		bit         typed;
		bit         typed_has;
		cmd_t       typed_cmd;
	} frame_row_t;

	logic                clk;
	logic                arst_n;
	logic                control_mode_wr_en;
	logic [1:0]          control_mode_wr_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;   // rx_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// base_action, base_speed, joint_action, joint_angle, claw_action, claw_angle, zero fill
	logic [TDATA_W-1:0]  m_axis_tdata;

	// predictor state
	frame_state_t        hunt_q;
	int unsigned         frame_fill;
	logic [7:0]          payload_q [PAYLOAD_LEN];
	logic [1:0]          mode_q;

	cmd_t                pending_cmds [$];
	frame_row_t          directed_frames [$];
	int                  err_count;
	int                  quiet_cycles;
	bit                  calm_run;
	bit                  hold_go;

	sync_frame_actuator_command_decoder DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.control_mode_wr_en   (control_mode_wr_en),
		.control_mode_wr_data (control_mode_wr_data),
		.s_axis_tvalid        (s_axis_tvalid),
		.s_axis_tready        (s_axis_tready),
		.s_axis_tdata         (s_axis_tdata),
		.m_axis_tvalid        (m_axis_tvalid),
		.m_axis_tready        (m_axis_tready),
		.m_axis_tdata         (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic cmd_t mk_cmd(input logic [1:0] ba, input logic [7:0] bs,
			input logic ja, input logic [7:0] jg, input logic ca, input logic [7:0] cg);
		cmd_t c;
		c.base_action  = ba;
		c.base_speed   = bs;
		c.joint_action = ja;
		c.joint_angle  = jg;
		c.claw_action  = ca;
		c.claw_angle   = cg;
		return c;
	endfunction

	function automatic cmd_t build_command(input logic [7:0] cw, input logic [7:0] ccw,
			input logic [7:0] rj, input logic [7:0] rc, input logic [7:0] sel);
		cmd_t       c;
		logic [2:0] en;   // {claw, joint, base}
		logic [8:0] jsum;
		en = 3'b000;
		if (!(sel == SEL_STOP || (sel == SEL_BASE && {cw, ccw, rj, rc} == 32'd0))) begin
			case (sel)
				SEL_AUTO:     en = {rc != 8'd0, rj != 8'd0, 1'b1};
				SEL_BASE:     en = 3'b001;
				SEL_JOINT:    en = 3'b010;
				SEL_CLAW:     en = 3'b100;
				SEL_BASE_JNT: en = 3'b011;
				SEL_BASE_CLW: en = 3'b101;
				SEL_JNT_CLW:  en = 3'b110;
				default:      en = 3'b000;
			endcase
		end
		c = '0;
		c.base_action = BASE_HALT;
		c.joint_angle = JOINT_BASE;
		// base moves only when exactly one direction byte is set
		if (en[0] && ((cw == 8'd0) != (ccw == 8'd0))) begin
			c.base_action = (cw != 8'd0) ? BASE_BWD : BASE_FWD;
			c.base_speed  = cw | ccw;
		end
		if (en[1]) begin
			jsum = {1'b0, rj} + {1'b0, JOINT_BASE};
			c.joint_action = 1'b1;
			c.joint_angle  = (jsum > {1'b0, JOINT_MAX}) ? JOINT_MAX : jsum[7:0];
		end
		if (en[2]) begin
			c.claw_action = 1'b1;
			c.claw_angle  = (rc > CLAW_MAX) ? CLAW_MAX : rc;
		end
		return c;
	endfunction

	// advances the frame tracker by one byte, returns 1 when a command comes out
	function automatic bit track_byte(input logic [7:0] b, output cmd_t c);
		c = '0;
		if (hunt_q == ST_HUNT) begin
			if (b == HDR_BYTE) begin
				hunt_q     = ST_FRAME;
				frame_fill = 1;
			end
			return 1'b0;
		end
		if (b == HDR_BYTE) begin
			frame_fill = 1;
			return 1'b0;
		end
		if (frame_fill < PAYLOAD_LEN + 1) begin
			payload_q[frame_fill - 1] = b;
			frame_fill++;
			return 1'b0;
		end
		hunt_q     = ST_HUNT;
		frame_fill = 0;
		if (b != TAIL_BYTE || mode_q != MODE_AUTO)
			return 1'b0;
		c = build_command(payload_q[0], payload_q[1], payload_q[2], payload_q[3],
			payload_q[4]);
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input bit typed_has = 1'b0, input cmd_t typed_cmd = '0);
		int   gap;
		bit   has;
		cmd_t c;
		if (!calm_run && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		has = track_byte(b, c);
		if (typed) begin
			has = typed_has;
			c   = typed_cmd;
		end
		if (has)
			pending_cmds.push_back(c);
	endtask

	// stop offering bytes, let every command drain, then let the pipeline go quiet
	task automatic settle();
		int n;
		n = 0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_cmds.size() != 0 && n < 500) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		settle();
		@(negedge clk);
		control_mode_wr_en   <= 1'b1;
		control_mode_wr_data <= m;
		@(negedge clk);
		control_mode_wr_en   <= 1'b0;
		mode_q = m;
	endtask

	task automatic send_row(input frame_row_t r);
		if (r.cut > 0) begin
			send_byte(HDR_BYTE);
			send_byte(r.cw);
			if (r.cut > 1) send_byte(r.ccw);
			if (r.cut > 2) send_byte(r.rj);
		end
		send_byte(HDR_BYTE);
		send_byte(r.cw);
		send_byte(r.ccw);
		send_byte(r.rj);
		send_byte(r.rc);
		send_byte(r.sel);
		send_byte(r.tail, r.typed, r.typed_has, r.typed_cmd);
	endtask

	function automatic void add_frame(input logic [1:0] mode, input logic [7:0] cw,
			input logic [7:0] ccw, input logic [7:0] rj, input logic [7:0] rc,
			input logic [7:0] sel, input logic [7:0] tail, input int cut,
			input bit typed, input bit typed_has, input cmd_t typed_cmd);
		frame_row_t r;
		r.mode      = mode;
		r.cw        = cw;
		r.ccw       = ccw;
		r.rj        = rj;
		r.rc        = rc;
		r.sel       = sel;
		r.tail      = tail;
		r.cut       = cut;
		r.typed     = typed;
		r.typed_has = typed_has;
		r.typed_cmd = typed_cmd;
		directed_frames.push_back(r);
	endfunction

	function automatic logic [7:0] pick_payload();
		logic [7:0] v;
		case ($urandom_range(0, 5))
			0:       v = 8'd0;
			1:       v = 8'd255;
			2:       v = 8'($urandom_range(55, 65));
			3:       v = 8'($urandom_range(135, 145));
			default: v = 8'($urandom_range(1, 255));
		endcase
		if (v == HDR_BYTE)
			v = HDR_BYTE + 8'd1;
		return v;
	endfunction

	function automatic logic [7:0] pick_selector();
		logic [7:0] v;
		if ($urandom_range(0, 9) < 8)
			v = 8'($urandom_range(0, 7));
		else
			v = 8'($urandom_range(8, 255));
		if (v == HDR_BYTE)
			v = HDR_BYTE + 8'd1;
		return v;
	endfunction

	task automatic send_random_frame();
		logic [7:0] body [6];
		int         kind;
		int         cut;
		for (int i = 0; i < 4; i++)
			body[i] = pick_payload();
		body[4] = pick_selector();
		body[5] = TAIL_BYTE;
		kind = $urandom_range(0, 9);
		cut  = $urandom_range(0, 5);
		if (kind == 0) begin
			body[5] = 8'($urandom_range(0, 255));
		end else if (kind == 1) begin
			// legacy all-zero stop frame
			for (int i = 0; i < 4; i++)
				body[i] = 8'd0;
			body[4] = SEL_BASE;
		end
		// line noise before the header
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
		send_byte(HDR_BYTE);
		for (int i = 0; i < 6; i++) begin
			if (kind == 2 && i == cut)
				send_byte(HDR_BYTE);
			if (kind == 3 && i == cut)
				break;
			send_byte(body[i]);
		end
	endtask

	// result side
	always @(posedge clk) begin
		cmd_t got;
		cmd_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = cmd_t'(m_axis_tdata[CMD_W-1:0]);
			if (pending_cmds.size() == 0) begin
				report_mismatch("unexpected command", int'(m_axis_tdata), 0);
			end else begin
				want = pending_cmds.pop_front();
				if (got.base_action != want.base_action)
					report_mismatch("base_action", got.base_action, want.base_action);
				if (got.base_speed != want.base_speed)
					report_mismatch("base_speed", got.base_speed, want.base_speed);
				if (got.joint_action != want.joint_action)
					report_mismatch("joint_action", got.joint_action, want.joint_action);
				if (got.joint_angle != want.joint_angle)
					report_mismatch("joint_angle", got.joint_angle, want.joint_angle);
				if (got.claw_action != want.claw_action)
					report_mismatch("claw_action", got.claw_action, want.claw_action);
				if (got.claw_angle != want.claw_angle)
					report_mismatch("claw_angle", got.claw_angle, want.claw_angle);
				if (m_axis_tdata[TDATA_W-1:CMD_W] != '0)
					report_mismatch("tdata fill", int'(m_axis_tdata[TDATA_W-1:CMD_W]), 0);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				control_mode_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sync_frame_actuator_command_decoder_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// command receiver with random back-pressure and one long hold-off
	initial begin
		int stall_left;
		int hold_left;
		stall_left    = 0;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_left = HOLD_CYCLES;
				hold_go   = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm_run && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		cmd_t       stop_all;
		logic [1:0] phase_mode [7];
		int         phase_frames [7];
		arst_n               = 1'b0;
		control_mode_wr_en   = 1'b0;
		control_mode_wr_data = 2'd0;
		s_axis_tvalid        = 1'b0;
		s_axis_tdata         = 8'd0;
		err_count            = 0;
		calm_run             = 1'b0;
		hold_go              = 1'b0;
		hunt_q               = ST_HUNT;
		frame_fill           = 0;
		mode_q               = 2'd0;
		for (int i = 0; i < PAYLOAD_LEN; i++)
			payload_q[i] = 8'd0;

		stop_all = mk_cmd(BASE_HALT, 8'd0, 1'b0, JOINT_BASE, 1'b0, 8'd0);
		// mode after reset is manual-off, so a good frame is swallowed
		add_frame(2'd0, 8'd10, 8'd0, 8'd20, 8'd30, SEL_AUTO, TAIL_BYTE, 0, 1, 0, '0);
		add_frame(MODE_AUTO, 8'd0, 8'd0, 8'd0, 8'd0, SEL_BASE, TAIL_BYTE, 0, 1, 1, stop_all);
		add_frame(MODE_AUTO, 8'd255, 8'd0, 8'd255, 8'd255, SEL_AUTO, TAIL_BYTE, 0, 1, 1,
			mk_cmd(BASE_BWD, 8'd255, 1'b1, JOINT_MAX, 1'b1, CLAW_MAX));
		add_frame(MODE_AUTO, 8'd0, 8'd255, 8'd0, 8'd0, SEL_AUTO, TAIL_BYTE, 0, 1, 1,
			mk_cmd(BASE_FWD, 8'd255, 1'b0, JOINT_BASE, 1'b0, 8'd0));
		add_frame(MODE_AUTO, 8'd5, 8'd6, 8'd60, 8'd140, SEL_STOP, TAIL_BYTE, 0, 1, 1,
			stop_all);
		add_frame(MODE_AUTO, 8'd5, 8'd0, 8'd1, 8'd1, 8'hFF, TAIL_BYTE, 0, 1, 1, stop_all);
		// both directions set: base stops, joint just past the clamp
		add_frame(MODE_AUTO, 8'd7, 8'd7, 8'd61, 8'd141, SEL_BASE_JNT, TAIL_BYTE, 0, 0, 0, '0);
		add_frame(MODE_AUTO, 8'd0, 8'd0, 8'd60, 8'd139, SEL_JNT_CLW, TAIL_BYTE, 0, 0, 0, '0);
		add_frame(MODE_AUTO, 8'd1, 8'd0, 8'd59, 8'd140, SEL_BASE_CLW, TAIL_BYTE, 0, 0, 0, '0);
		add_frame(MODE_AUTO, 8'd0, 8'd0, 8'd10, 8'd0, SEL_JOINT, TAIL_BYTE, 0, 0, 0, '0);
		add_frame(MODE_AUTO, 8'd0, 8'd0, 8'd0, 8'd200, SEL_CLAW, TAIL_BYTE, 0, 0, 0, '0);
		add_frame(MODE_AUTO, 8'd0, 8'd9, 8'd0, 8'd0, SEL_BASE, TAIL_BYTE, 0, 0, 0, '0);
		add_frame(MODE_AUTO, 8'd3, 8'd0, 8'd4, 8'd5, SEL_BASE, 8'hFE, 0, 1, 0, '0);
		// header arrives inside a partial frame and restarts it
		add_frame(MODE_AUTO, 8'd12, 8'd0, 8'd1, 8'd2, SEL_AUTO, TAIL_BYTE, 3, 0, 0, '0);
		add_frame(2'd2, 8'd12, 8'd0, 8'd1, 8'd2, SEL_BASE, TAIL_BYTE, 0, 1, 0, '0);
		add_frame(2'd3, 8'd12, 8'd0, 8'd1, 8'd2, SEL_BASE, TAIL_BYTE, 0, 1, 0, '0);

		phase_mode   = '{MODE_AUTO, 2'd2, MODE_AUTO, 2'd3, MODE_AUTO, 2'd0, MODE_AUTO};
		phase_frames = '{10, 2, 12, 2, 9, 2, 8};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_frames[i]) begin
			if (directed_frames[i].mode != mode_q)
				write_mode(directed_frames[i].mode);
			send_row(directed_frames[i]);
		end

		for (int p = 0; p < 7; p++) begin
			if (phase_mode[p] != mode_q)
				write_mode(phase_mode[p]);
			calm_run = (p == 6);
			if (p == 2)
				hold_go = 1'b1;
			repeat (phase_frames[p]) send_random_frame();
		end

		settle();
		if (pending_cmds.size() != 0)
			report_mismatch("commands never seen", pending_cmds.size(), 0);
		if (err_count == 0) begin
			$display("sync_frame_actuator_command_decoder_tb passed");
		end else begin
			$display("sync_frame_actuator_command_decoder_tb failed");
		end
		$finish;
	end

endmodule
